// File: rtl/mlk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mlk_pkg: shared types and constants of the morse letter keyer
// holds the keyer state record, the result record, the status and opcode
// codes and the fixed letter pattern table
// ---------------------------------------------------------------------------
package mlk_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int LETTER_WIDTH = 8;
   localparam int PATTERN_WIDTH = 8;
   localparam int INDEX_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] DOT_RESET = 16'd400;
   localparam logic [COUNT_WIDTH-1:0] DASH_RESET = 16'd1400;
   localparam logic [LETTER_WIDTH-1:0] LETTER_FIRST = 8'd97;   // 'a'
   localparam logic [LETTER_WIDTH-1:0] LETTER_LAST = 8'd122;   // 'z'

   // request opcodes
   localparam logic OP_LETTER = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // csr register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOT_TICKS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DASH_TICKS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BUSY = 2'd1,
      STATUS_BAD_LETTER = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ELEM_END = 2'd0,
      ELEM_DOT = 2'd1,
      ELEM_DASH = 2'd2
   } elem_code_type;

   typedef struct packed {
      logic [PATTERN_WIDTH-1:0] pattern;
      logic [INDEX_WIDTH-1:0] element_index;
      logic off_phase;
      logic [COUNT_WIDTH-1:0] ticks_left;
      logic active;
   } keyer_state_type;

   typedef struct packed {
      logic led_level;
      logic busy_res;
      status_type status;
   } keyer_result_type;

   // pack four element codes, first element in the low bits
   function automatic logic [PATTERN_WIDTH-1:0] pat(input logic [1:0] e0,
                                                    input logic [1:0] e1,
                                                    input logic [1:0] e2,
                                                    input logic [1:0] e3);
      pat = {e3, e2, e1, e0};
   endfunction

   // letter pattern table, index 0 is 'a'
   function automatic logic [PATTERN_WIDTH-1:0] letter_pattern(input logic [4:0] idx);
      logic [PATTERN_WIDTH-1:0] p;
      unique case (idx)
         5'd0:  p = pat(2'd1, 2'd2, 2'd0, 2'd0);
         5'd1:  p = pat(2'd2, 2'd1, 2'd1, 2'd1);
         5'd2:  p = pat(2'd2, 2'd1, 2'd2, 2'd1);
         5'd3:  p = pat(2'd2, 2'd1, 2'd1, 2'd0);
         5'd4:  p = pat(2'd1, 2'd0, 2'd0, 2'd0);
         5'd5:  p = pat(2'd1, 2'd1, 2'd2, 2'd1);
         5'd6:  p = pat(2'd2, 2'd2, 2'd1, 2'd0);
         5'd7:  p = pat(2'd1, 2'd1, 2'd1, 2'd1);
         5'd8:  p = pat(2'd1, 2'd1, 2'd0, 2'd0);
         5'd9:  p = pat(2'd1, 2'd2, 2'd2, 2'd2);
         5'd10: p = pat(2'd2, 2'd1, 2'd2, 2'd0);
         5'd11: p = pat(2'd1, 2'd2, 2'd1, 2'd1);
         5'd12: p = pat(2'd2, 2'd2, 2'd0, 2'd0);
         5'd13: p = pat(2'd2, 2'd1, 2'd0, 2'd0);
         5'd14: p = pat(2'd2, 2'd2, 2'd2, 2'd0);
         5'd15: p = pat(2'd1, 2'd2, 2'd2, 2'd1);
         5'd16: p = pat(2'd2, 2'd2, 2'd1, 2'd2);
         5'd17: p = pat(2'd1, 2'd2, 2'd1, 2'd0);
         5'd18: p = pat(2'd1, 2'd1, 2'd1, 2'd0);
         5'd19: p = pat(2'd2, 2'd0, 2'd0, 2'd0);
         5'd20: p = pat(2'd1, 2'd1, 2'd2, 2'd0);
         5'd21: p = pat(2'd1, 2'd1, 2'd1, 2'd2);
         5'd22: p = pat(2'd1, 2'd2, 2'd2, 2'd0);
         5'd23: p = pat(2'd2, 2'd1, 2'd1, 2'd2);
         5'd24: p = pat(2'd2, 2'd1, 2'd2, 2'd2);
         5'd25: p = pat(2'd2, 2'd2, 2'd1, 2'd1);
         default: p = '0;
      endcase
      letter_pattern = p;
   endfunction

   // element code at a position; four slots at most, codes 0 and 3 end the letter
   function automatic elem_code_type element_code(input logic [PATTERN_WIDTH-1:0] p,
                                                  input logic [INDEX_WIDTH-1:0] idx);
      logic [1:0] raw;
      raw = p[{idx[1:0], 1'b0} +: 2];
      if (idx[2]) begin
         element_code = ELEM_END;
      end else if (raw == ELEM_DOT) begin
         element_code = ELEM_DOT;
      end else if (raw == ELEM_DASH) begin
         element_code = ELEM_DASH;
      end else begin
         element_code = ELEM_END;
      end
   endfunction

   // phase length in ticks; a zero register counts as one tick
   function automatic logic [COUNT_WIDTH-1:0] duration(input elem_code_type code,
                                                       input logic [COUNT_WIDTH-1:0] dot,
                                                       input logic [COUNT_WIDTH-1:0] dash);
      logic [COUNT_WIDTH-1:0] d;
      d = (code == ELEM_DASH) ? dash : dot;
      duration = (d == '0) ? COUNT_WIDTH'(1) : d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/morse_letter_keyer.sv
`default_nettype none
// a response is registered and shows up in the cycle after its request transaction
// throughput: one request transaction per cycle while responses drain
// ready is low only while a response waits and the consumer is stalled
// reset: synchronous, active high; idle with the led dark, dot 400 ticks,
// dash 1400 ticks, no response pending
// ---------------------------------------------------------------------------
// morse_letter_keyer: keys one lowercase letter as morse code on a led line
// a letter transaction loads its dot/dash pattern while idle, tick transactions step the
// on and off phases of each element; every transaction returns one response
// ---------------------------------------------------------------------------
module morse_letter_keyer (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_valid,
   output logic req_ready,
   input  logic req_opcode,
   input  logic [mlk_pkg::LETTER_WIDTH-1:0] req_letter_byte,
   // response channel
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_led_level,
   output logic rsp_busy_res,
   output logic [1:0] rsp_status,
   // csr write port
   input  logic csr_wr_en,
   input  logic [mlk_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mlk_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import mlk_pkg::*;

   // keyer state and timing registers
   keyer_state_type state_ff;
   keyer_state_type state_in;
   logic [COUNT_WIDTH-1:0] dot_ticks_ff;
   logic [COUNT_WIDTH-1:0] dash_ticks_ff;

   // response register
   logic rsp_valid_ff;
   keyer_result_type rsp_ff;
   keyer_result_type rsp_in;

   logic req_accept;

   // take a new request whenever the response slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   mlk_next u_next (
      .state       (state_ff),
      .dot_ticks   (dot_ticks_ff),
      .dash_ticks  (dash_ticks_ff),
      .opcode      (req_opcode),
      .letter_byte (req_letter_byte),
      .state_next  (state_in),
      .result      (rsp_in)
   );

   // state only moves on an accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // csr writes must only land while idle; the block does not enforce it and has no interlock with keying
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ticks_ff <= DOT_RESET;
         dash_ticks_ff <= DASH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DOT_TICKS: dot_ticks_ff <= csr_wdata;
            CSR_DASH_TICKS: dash_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // response valid: set by an accept, cleared when taken without a refill
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_level = rsp_ff.led_level;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_status = rsp_ff.status;

endmodule
`default_nettype wire

// File: rtl/mlk_next.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mlk_next: keyer next-state logic
// works out the state after one transaction and the result it reports
// ---------------------------------------------------------------------------
module mlk_next (
   input  mlk_pkg::keyer_state_type state,
   input  logic [mlk_pkg::COUNT_WIDTH-1:0] dot_ticks,
   input  logic [mlk_pkg::COUNT_WIDTH-1:0] dash_ticks,
   input  logic opcode,
   input  logic [mlk_pkg::LETTER_WIDTH-1:0] letter_byte,
   output mlk_pkg::keyer_state_type state_next,
   output mlk_pkg::keyer_result_type result
);
   import mlk_pkg::*;

   logic letter_ok;
   logic [LETTER_WIDTH-1:0] letter_offset;
   logic [PATTERN_WIDTH-1:0] new_pattern;
   logic [COUNT_WIDTH-1:0] ticks_dec;
   logic [INDEX_WIDTH-1:0] next_index;
   elem_code_type cur_code;
   elem_code_type next_code;
   status_type status;

   assign letter_ok = (letter_byte >= LETTER_FIRST) && (letter_byte <= LETTER_LAST);
   assign letter_offset = letter_byte - LETTER_FIRST;
   assign new_pattern = letter_pattern(letter_offset[4:0]);
   assign ticks_dec = (state.ticks_left != '0) ? state.ticks_left - COUNT_WIDTH'(1)
                                                : state.ticks_left;
   assign next_index = state.element_index + INDEX_WIDTH'(1);
   assign cur_code = element_code(state.pattern, state.element_index);
   assign next_code = element_code(state.pattern, next_index);

   always_comb begin
      state_next = state;
      status = STATUS_OK;
      if (opcode == OP_LETTER) begin
         if (state.active) begin
            status = STATUS_BUSY;
         end else if (!letter_ok) begin
            status = STATUS_BAD_LETTER;
         end else begin
            state_next.pattern = new_pattern;
            state_next.element_index = '0;
            state_next.off_phase = 1'b0;
            state_next.ticks_left = duration(element_code(new_pattern, '0),
                                             dot_ticks, dash_ticks);
            state_next.active = 1'b1;
         end
      end else if (state.active) begin
         state_next.ticks_left = ticks_dec;
         if (ticks_dec == '0) begin
            if (!state.off_phase) begin
               // on part done, hold dark for the same length
               state_next.off_phase = 1'b1;
               state_next.ticks_left = duration(cur_code, dot_ticks, dash_ticks);
            end else if (next_code != ELEM_END) begin
               state_next.element_index = next_index;
               state_next.off_phase = 1'b0;
               state_next.ticks_left = duration(next_code, dot_ticks, dash_ticks);
            end else begin
               // letter finished
               state_next.active = 1'b0;
               state_next.off_phase = 1'b0;
               state_next.element_index = '0;
               state_next.ticks_left = '0;
            end
         end
      end
   end

   assign result.led_level = state_next.active && !state_next.off_phase;
   assign result.busy_res = state_next.active;
   assign result.status = status;

endmodule
`default_nettype wire

// File: tb/sv/morse_letter_keyer_tb.sv
// ---------------------------------------------------------------------------
// morse_letter_keyer_tb: self-checking testbench of the morse letter keyer
// drives letter and tick transactions with random gaps and stalls, predicts
// the led, busy and status of every response in a scoreboard and compares
// them field by field over several dot and dash duration settings
// ---------------------------------------------------------------------------
module morse_letter_keyer_tb;
   import mlk_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int MAX_REPORTS = 10;

   // predicts the keyer response of every request transaction
   class keyer_scoreboard;
      logic [COUNT_WIDTH-1:0] dot_len;
      logic [COUNT_WIDTH-1:0] dash_len;
      string cur_letter;
      int elem_pos;
      bit in_gap;
      logic [COUNT_WIDTH-1:0] remaining;
      bit keying;
      keyer_result_type expected_q[$];
      int errors;

      function new();
         dot_len = 16'd400;
         dash_len = 16'd1400;
         cur_letter = "";
         elem_pos = 0;
         in_gap = 0;
         remaining = '0;
         keying = 0;
         errors = 0;
      endfunction

      function string morse_of(int idx);
         case (idx)
            0: return ".-";
            1: return "-...";
            2: return "-.-.";
            3: return "-..";
            4: return ".";
            5: return "..-.";
            6: return "--.";
            7: return "....";
            8: return "..";
            9: return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
         endcase
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] v);
         if (idx == CSR_DOT_TICKS) begin
            dot_len = v;
         end else begin
            dash_len = v;
         end
      endfunction

      function elem_code_type code_at(int pos);
         if (pos >= cur_letter.len()) begin
            return ELEM_END;
         end
         return (cur_letter[pos] == "-") ? ELEM_DASH : ELEM_DOT;
      endfunction

      // a zero register still keys for one tick
      function logic [COUNT_WIDTH-1:0] phase_len(elem_code_type c);
         logic [COUNT_WIDTH-1:0] d;
         d = (c == ELEM_DASH) ? dash_len : dot_len;
         return (d == '0) ? COUNT_WIDTH'(1) : d;
      endfunction

      function void note_request(logic op, logic [LETTER_WIDTH-1:0] b);
         keyer_result_type r;
         elem_code_type nxt;
         r.status = STATUS_OK;
         if (op == OP_LETTER) begin
            if (keying) begin
               r.status = STATUS_BUSY;
            end else if (b < LETTER_FIRST || b > LETTER_LAST) begin
               r.status = STATUS_BAD_LETTER;
            end else begin
               cur_letter = morse_of(int'(b - LETTER_FIRST));
               elem_pos = 0;
               in_gap = 0;
               remaining = phase_len(code_at(0));
               keying = 1;
            end
         end else if (keying) begin
            if (remaining != '0) begin
               remaining = remaining - 1'b1;
            end
            if (remaining == '0) begin
               if (!in_gap) begin
                  in_gap = 1;
                  remaining = phase_len(code_at(elem_pos));
               end else begin
                  nxt = code_at(elem_pos + 1);
                  if (nxt != ELEM_END) begin
                     elem_pos++;
                     in_gap = 0;
                     remaining = phase_len(nxt);
                  end else begin
                     keying = 0;
                     in_gap = 0;
                     elem_pos = 0;
                  end
               end
            end
         end
         r.led_level = keying && !in_gap;
         r.busy_res = keying;
         expected_q.push_back(r);
      endfunction

      function void check_response(logic led, logic busy, logic [1:0] st);
         keyer_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected response: led %b busy %b status %0d", led, busy, st);
            end
            return;
         end
         want = expected_q.pop_front();
         if (led !== want.led_level || busy !== want.busy_res || st !== want.status) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("response mismatch: expected led %b busy %b status %0d,",
                        want.led_level, want.busy_res, want.status,
                        " got led %b busy %b status %0d", led, busy, st);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_TICK;
   logic [LETTER_WIDTH-1:0] req_letter_byte = '0;

   // response side
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_led_level;
   logic rsp_busy_res;
   logic [1:0] rsp_status;

   // csr write port
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   keyer_scoreboard sb;
   bit send_idle_en = 1'b1;
   bit recv_idle_en = 1'b1;
   int recv_hold = 0;
   int cycle_count = 0;

   morse_letter_keyer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_letter_byte(req_letter_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_led_level(rsp_led_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // one request transaction; starts and ends at a falling edge, valid
   // stays high on return so back-to-back transactions need no extra step
   task automatic send_request(input logic op, input logic [LETTER_WIDTH-1:0] b);
      int gap;
      gap = send_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_letter_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, b);
      @(negedge clock);
   endtask

   // a random byte in a..z, or any byte now and then
   function automatic logic [LETTER_WIDTH-1:0] pick_letter();
      if ($urandom_range(0, 3) != 0) begin
         return LETTER_FIRST + LETTER_WIDTH'($urandom_range(0, 25));
      end
      return LETTER_WIDTH'($urandom_range(0, 255));
   endfunction

   // ticks until the predicted keyer has gone idle
   task automatic finish_letter();
      while (sb.keying) begin
         send_request(OP_TICK, LETTER_WIDTH'($urandom_range(0, 255)));
      end
   endtask

   // drop valid and wait until every response has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   // only called while the keyer is idle and all responses are in
   task automatic set_durations(input logic [CSR_DATA_WIDTH-1:0] dot,
                                input logic [CSR_DATA_WIDTH-1:0] dash);
      write_csr(CSR_DOT_TICKS, dot);
      write_csr(CSR_DASH_TICKS, dash);
      csr_wr_en <= 1'b0;
   endtask

   // random mix: letters mostly while idle, ticks mostly while keying,
   // with a few busy rejects and invalid bytes
   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (!sb.keying && $urandom_range(0, 9) < 7) begin
            send_request(OP_LETTER, pick_letter());
         end else if (sb.keying && $urandom_range(0, 19) == 0) begin
            send_request(OP_LETTER, pick_letter());
         end else begin
            send_request(OP_TICK, LETTER_WIDTH'($urandom_range(0, 255)));
         end
      end
      finish_letter();
   endtask

   // response stalls, picked at the falling edge
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         rsp_ready <= 1'b0;
         recv_hold--;
      end else begin
         rsp_ready <= 1'b1;
         if (recv_idle_en && $urandom_range(0, 3) == 0) begin
            recv_hold = pick_gap();
         end
      end
   end

   // response transactions are checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_led_level, rsp_busy_res, rsp_status);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] dot_pick;
      logic [CSR_DATA_WIDTH-1:0] dash_pick;
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset durations: ticks while idle, invalid
      // bytes at both edges of a..z, a single-dot letter, rejects while busy
      send_request(OP_TICK, 8'h00);
      send_request(OP_TICK, 8'hff);
      send_request(OP_LETTER, 8'h00);
      send_request(OP_LETTER, LETTER_FIRST - 1'b1);
      send_request(OP_LETTER, LETTER_LAST + 1'b1);
      send_request(OP_LETTER, 8'h80);
      send_request(OP_LETTER, 8'hff);
      send_request(OP_LETTER, LETTER_FIRST + 8'd4);
      send_request(OP_LETTER, LETTER_LAST);
      send_request(OP_LETTER, 8'hff);
      send_request(OP_LETTER, 8'h00);
      send_request(OP_TICK, 8'h55);
      send_request(OP_TICK, 8'haa);
      finish_letter();
      wait_drain();

      // every letter of the table once, dot of one tick and dash of two ticks
      set_durations(16'd1, 16'd2);
      for (int i = 0; i < 26; i++) begin
         send_request(OP_LETTER, LETTER_FIRST + LETTER_WIDTH'(i));
         finish_letter();
      end
      wait_drain();

      // random phases over several duration settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin dot_pick = 16'd1; dash_pick = 16'd1; end
            1: begin dot_pick = 16'd0; dash_pick = 16'd0; end
            2: begin dot_pick = 16'd1; dash_pick = 16'd3; end
            3: begin dot_pick = 16'd3; dash_pick = 16'd1; end
            4: begin dot_pick = 16'd2; dash_pick = 16'd7; end
            default: begin
               dot_pick = CSR_DATA_WIDTH'($urandom_range(0, 5));
               dash_pick = CSR_DATA_WIDTH'($urandom_range(0, 5));
            end
         endcase
         send_idle_en = ($urandom_range(0, 3) != 0);
         recv_idle_en = ($urandom_range(0, 3) != 0);
         set_durations(dot_pick, dash_pick);
         run_random(ITEMS_PER_PHASE);
         wait_drain();
      end

      // largest durations: a letter is loaded and ticked a little, the
      // full count is not run out
      send_idle_en = 1'b0;
      recv_idle_en = 1'b0;
      set_durations(16'hffff, 16'hffff);
      send_request(OP_LETTER, LETTER_FIRST + 8'd19);
      send_request(OP_TICK, 8'h00);
      send_request(OP_LETTER, LETTER_FIRST + 8'd4);
      send_request(OP_TICK, 8'hff);
      send_request(OP_TICK, 8'h00);
      wait_drain();

      // let any late response show up
      repeat (5) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: morse_letter_keyer.f
rtl/mlk_pkg.sv
rtl/mlk_next.sv
rtl/morse_letter_keyer.sv
tb/sv/morse_letter_keyer_tb.sv
